// File: design/dcrb_pkg.sv
// Shared types and fixed constants of the display controller register block.
`timescale 1ns / 1ps
package dcrb_pkg;

  localparam int unsigned ADDR_W  = 13;
  localparam int unsigned SIZE_W  = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned START_W = 21;

  // Register map (byte offsets of words)
  localparam logic [ADDR_W-1:0] ID_ADDR     = 13'h0000;
  localparam logic [ADDR_W-1:0] STATUS_ADDR = 13'h0140;
  localparam logic [ADDR_W-1:0] CTRL_ADDR   = 13'h0414;
  localparam logic [ADDR_W-1:0] OFFSET_ADDR = 13'h0418;
  localparam logic [ADDR_W-1:0] PITCH_ADDR  = 13'h041c;

  localparam logic [DATA_W-1:0] ID_VALUE     = 32'h5741_1002;
  localparam logic [DATA_W-1:0] STATUS_VALUE = 32'h0000_007f;
  localparam logic [DATA_W-1:0] FB_BASE      = 32'h0080_0000;

  localparam int unsigned       PITCH_RESET = 1280;
  localparam logic [SIZE_W-1:0] MAX_ACCESS  = 3'd4;

  typedef struct packed {
    logic              kind;
    logic              space;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] access_size;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic [START_W-1:0] scan_start;
    logic [DATA_W-1:0]  scan_pitch;
    logic               scan_active;
  } rsp_t;

endpackage

// File: design/dcrb_if.sv
// Valid/ready channel interfaces for bus accesses and their results.
`timescale 1ns / 1ps
interface dcrb_req_if;
  import dcrb_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dcrb_rsp_if;
  import dcrb_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: design/display_controller_register_block_top.sv
// Top level of the display controller register block.
`timescale 1ns / 1ps
// One bus transaction per cycle goes in while the result side keeps up, and
// one result comes out for each, two register stages later. At the accepting
// edge the register file port is read or written, configuration bytes are
// moved and the side-effect registers (frame offset, pitch, portrait field)
// are updated; stage one then works out the scan-out start from those
// registers and loads the result register when it is free. The single
// register file port, used once per transaction, sets the rate of one
// transaction per cycle. After reset the register file is swept to zero, one
// word a cycle, REG_BYTES/4 words (2048 by default); ready is low until done.
module display_controller_register_block_top #(
  parameter int unsigned REG_BYTES       = 8192,
  parameter int unsigned CFG_SPACE_BYTES = 16,
  parameter int unsigned DISPLAY_ROWS    = 480,
  parameter int unsigned VRAM_BYTES      = 2097152
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dcrb_req_if.sink   req_i,
  dcrb_rsp_if.source rsp_o
);
  import dcrb_pkg::*;

  localparam int unsigned NWORDS  = REG_BYTES / 4;
  localparam int unsigned IDX_W   = $clog2(NWORDS);
  localparam int unsigned ROW_W   = $clog2(DISPLAY_ROWS + 1);
  localparam int unsigned PROD_W  = DATA_W + ROW_W;
  localparam int unsigned LIM_W   = PROD_W + 2;
  localparam int unsigned CFG_W   = CFG_SPACE_BYTES * 8;

  // Reset images of the pitch-derived registers
  localparam logic [PROD_W-1:0] BASE_RST =
    PROD_W'(longint'(DISPLAY_ROWS - 1) * longint'(PITCH_RESET));
  localparam logic [LIM_W-1:0] LIM_RST =
    LIM_W'(longint'(VRAM_BYTES) - longint'(DISPLAY_ROWS) * longint'(PITCH_RESET));

  // ---------------------------------------------------------------------
  // Handshake and stage control
  // ---------------------------------------------------------------------
  logic clr_busy_q;
  logic [IDX_W-1:0] clr_idx_q;
  logic s1_valid_q;
  logic out_valid_q;
  logic out_free;
  logic s1_adv;
  logic acc;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign s1_adv      = s1_valid_q && out_free;
  // After the sweep, take a new transaction whenever stage one is empty or moves on
  assign req_i.ready = !clr_busy_q && (!s1_valid_q || out_free);
  assign acc         = req_i.valid && req_i.ready;

  // ---------------------------------------------------------------------
  // Address decode
  // ---------------------------------------------------------------------
  req_t rq;
  logic [DATA_W-1:0] word_ext;
  logic              in_range;
  logic [IDX_W-1:0]  widx;
  logic [ADDR_W-1:0] off;
  logic              reg_wr;

  assign rq       = req_i.payload;
  assign word_ext = DATA_W'(rq.address[ADDR_W-1:2]);
  assign in_range = word_ext < DATA_W'(NWORDS);
  assign widx     = word_ext[IDX_W-1:0];
  // Word-aligned offset: ignore the two low address bits
  assign off      = {rq.address[ADDR_W-1:2], 2'b00};
  assign reg_wr   = acc && rq.kind && rq.space && in_range;

  // ---------------------------------------------------------------------
  // Register file: one port, swept to zero after reset
  // ---------------------------------------------------------------------
  logic [DATA_W-1:0] mem_q [NWORDS];
  logic [DATA_W-1:0] mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_idx_q] <= '0;
    end else if (reg_wr) begin
      mem_q[widx] <= rq.write_data;
    end
    if (acc) begin
      mem_rd_q <= mem_q[widx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_idx_q == IDX_W'(NWORDS - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Configuration byte space, little-endian, bytes past the end dropped
  // ---------------------------------------------------------------------
  logic [7:0]        cfg_q [CFG_SPACE_BYTES];
  logic [SIZE_W-1:0] sz;
  logic              cfg_wr;
  logic              cfg_hit  [CFG_SPACE_BYTES];
  logic [7:0]        cfg_byte [CFG_SPACE_BYTES];
  logic [CFG_W-1:0]  cfg_flat;
  logic [CFG_W-1:0]  cfg_shift;
  logic [DATA_W-1:0] cfg_rd;

  // Clamp oversized accesses to a full word
  assign sz     = (rq.access_size > MAX_ACCESS) ? MAX_ACCESS : rq.access_size;
  assign cfg_wr = acc && rq.kind && !rq.space;

  always_comb begin
    logic [ADDR_W:0] diff;
    for (int j = 0; j < CFG_SPACE_BYTES; j++) begin
      diff        = {1'b0, ADDR_W'(j)} - {1'b0, rq.address};
      cfg_hit[j]  = !diff[ADDR_W] && (diff[ADDR_W-1:0] < ADDR_W'(sz));
      cfg_byte[j] = rq.write_data[8*diff[1:0] +: 8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < CFG_SPACE_BYTES; j++) begin
        cfg_q[j] <= '0;
      end
    end else if (cfg_wr) begin
      for (int j = 0; j < CFG_SPACE_BYTES; j++) begin
        if (cfg_hit[j]) begin
          cfg_q[j] <= cfg_byte[j];
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < CFG_SPACE_BYTES; j++) begin
      cfg_flat[8*j +: 8] = cfg_q[j];
    end
  end

  // One window read at the access address, then mask lanes not moved
  assign cfg_shift = cfg_flat >> {rq.address, 3'b000};

  always_comb begin
    logic [ADDR_W:0] ai;
    cfg_rd = '0;
    for (int i = 0; i < 4; i++) begin
      ai = {1'b0, rq.address} + (ADDR_W + 1)'(i);
      if ((SIZE_W'(i) < sz) && (ai < (ADDR_W + 1)'(CFG_SPACE_BYTES))) begin
        cfg_rd[8*i +: 8] = cfg_shift[8*i +: 8];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Read value selection, settled at the accepting edge
  // ---------------------------------------------------------------------
  logic [DATA_W-1:0] fixed_d, fixed_q;
  logic              use_mem_d, use_mem_q;

  always_comb begin
    fixed_d   = '0;
    use_mem_d = 1'b0;
    if (!rq.kind) begin
      if (!rq.space) begin
        fixed_d = cfg_rd;
      end else if (in_range) begin
        if (off == ID_ADDR) begin
          fixed_d = ID_VALUE;
        end else if (off == STATUS_ADDR) begin
          fixed_d = STATUS_VALUE;
        end else begin
          use_mem_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      fixed_q   <= fixed_d;
      use_mem_q <= use_mem_d;
    end
  end

  // ---------------------------------------------------------------------
  // Side-effect registers; pitch products are formed as the pitch lands
  // ---------------------------------------------------------------------
  logic [DATA_W-1:0]       offset_q, offset_d;
  logic [DATA_W-1:0]       pitch_q;
  logic [PROD_W-1:0]       base_q, base_d;
  logic [PROD_W-1:0]       frame_d;
  logic signed [LIM_W-1:0] lim_q;
  logic [LIM_W-1:0]        lim_d;
  logic [1:0]              portrait_q;

  assign offset_d = (rq.write_data >= FB_BASE) ? (rq.write_data - FB_BASE) : '0;
  assign base_d   = PROD_W'(DISPLAY_ROWS - 1) * PROD_W'(rq.write_data);
  assign frame_d  = PROD_W'(DISPLAY_ROWS) * PROD_W'(rq.write_data);
  // Room left in VRAM for the start once a whole frame is placed
  assign lim_d    = LIM_W'(VRAM_BYTES) - {2'b00, frame_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      pitch_q    <= DATA_W'(PITCH_RESET);
      base_q     <= BASE_RST;
      lim_q      <= LIM_RST;
      portrait_q <= '0;
    end else if (reg_wr) begin
      if (off == OFFSET_ADDR) begin
        offset_q <= offset_d;
      end else if (off == PITCH_ADDR) begin
        pitch_q <= rq.write_data;
        base_q  <= base_d;
        lim_q   <= lim_d;
      end else if (off == CTRL_ADDR) begin
        portrait_q <= rq.write_data[4:3];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage one: scan-out start from the updated registers
  // ---------------------------------------------------------------------
  logic [PROD_W-1:0] eff_base;
  logic [PROD_W:0]   start_diff;
  logic [DATA_W-1:0] start_raw;
  logic              over_end;
  logic [DATA_W-1:0] start_fin;
  logic [DATA_W-1:0] rd_s1;

  // Portrait field odd (1 or 3): rotate about the last row
  assign eff_base   = portrait_q[0] ? base_q : '0;
  assign start_diff = {1'b0, PROD_W'(offset_q)} - {1'b0, eff_base};
  assign start_raw  = start_diff[PROD_W] ? '0 : start_diff[DATA_W-1:0];
  assign over_end   = $signed({{(LIM_W - DATA_W){1'b0}}, start_raw}) > lim_q;
  assign start_fin  = over_end ? '0 : start_raw;
  assign rd_s1      = use_mem_q ? mem_rd_q : fixed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  rsp_t out_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.read_data   <= rd_s1;
      out_q.scan_start  <= start_fin[START_W-1:0];
      out_q.scan_pitch  <= pitch_q;
      out_q.scan_active <= (pitch_q != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

endmodule

// File: tb/display_controller_register_block_top_test.sv
// Self-checking testbench for the display controller register block top level.
`timescale 1ns / 1ps
module display_controller_register_block_top_test;
  import dcrb_pkg::*;

  // Block sizes, passed to the instance and shared with the predictor
  localparam int unsigned REG_BYTES       = 8192;
  localparam int unsigned CFG_SPACE_BYTES = 16;
  localparam int unsigned DISPLAY_ROWS    = 480;
  localparam int unsigned VRAM_BYTES      = 2097152;
  localparam int unsigned REG_WORDS       = REG_BYTES / 4;

  // Transaction codes
  localparam bit ACC_READ  = 1'b0;
  localparam bit ACC_WRITE = 1'b1;
  localparam bit SPACE_CFG = 1'b0;
  localparam bit SPACE_REG = 1'b1;

  localparam int unsigned RANDOM_ACCESSES = 650;
  localparam int unsigned SEGMENT_LEN     = 80;
  // Two register stages from acceptance to result; allow a few spare cycles
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct {
    req_t acc;
    bit   typed;
    rsp_t want;
  } access_row_t;

  logic clk_i;
  logic rst_ni;

  dcrb_req_if req_bus ();
  dcrb_rsp_if rsp_bus ();

  display_controller_register_block_top #(
    .REG_BYTES       (REG_BYTES),
    .CFG_SPACE_BYTES (CFG_SPACE_BYTES),
    .DISPLAY_ROWS    (DISPLAY_ROWS),
    .VRAM_BYTES      (VRAM_BYTES)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Shadow copy of the block state, updated at each accepted transaction
  logic [DATA_W-1:0] reg_file [REG_WORDS];
  logic [7:0]        cfg_space [CFG_SPACE_BYTES];
  logic [DATA_W-1:0] frame_off;
  logic [DATA_W-1:0] line_pitch;

  // Results still owed by the block, oldest first
  rsp_t        pending_results [$];
  access_row_t directed_rows [$];

  int unsigned fault_count;
  bit          no_idle;

  // Row flag and value travel with the payload so that the monitor can pick
  // the typed-in expectation instead of the predicted one
  bit   row_typed;
  rsp_t row_want;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop: the slowest clean run (register sweep, then every transaction
  // waiting out the longest gap and the longest result stall) is well under
  // a millisecond, so several times that is allowed here.
  initial begin
    #4_000_000;
    $display("display_controller_register_block_top_test: done, errors");
    $finish;
  end

  // Gap length for either side: mostly none or short, a few long; none at
  // all while a quiet stretch is in force.
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Scan-out start from the shadow state; done in 64 bits so nothing wraps.
  function automatic logic [START_W-1:0] scan_origin();
    longint unsigned rows_less;
    longint unsigned rows_all;
    longint unsigned base;
    longint unsigned origin;
    logic [DATA_W-1:0] ctrl_word;
    rows_less = DISPLAY_ROWS - 1;
    rows_all  = DISPLAY_ROWS;
    ctrl_word = reg_file[CTRL_ADDR >> 2];
    // Portrait field odd means the frame is rotated: step back by all rows but one
    base = ctrl_word[3] ? rows_less * line_pitch : 0;
    origin = frame_off;
    origin = (origin >= base) ? origin - base : 0;
    // Drop to zero if the frame would run off the end of VRAM
    if (origin + rows_all * line_pitch > VRAM_BYTES) origin = 0;
    return origin[START_W-1:0];
  endfunction

  // Apply one transaction to the shadow state and return its result
  function automatic rsp_t apply_access(req_t acc);
    rsp_t              res;
    logic [DATA_W-1:0] rd;
    logic [ADDR_W-1:0] word_addr;
    int unsigned       n;
    int unsigned       a;
    int unsigned       i;
    int unsigned       idx;
    rd = '0;
    if (acc.space == SPACE_CFG) begin
      n = (acc.access_size > MAX_ACCESS) ? MAX_ACCESS : acc.access_size;
      for (i = 0; i < n; i++) begin
        a = acc.address + i;
        // Bytes beyond the configuration space go nowhere and read as zero
        if (a < CFG_SPACE_BYTES) begin
          if (acc.kind == ACC_WRITE) cfg_space[a] = acc.write_data[8*i +: 8];
          else rd[8*i +: 8] = cfg_space[a];
        end
      end
    end else begin
      word_addr = {acc.address[ADDR_W-1:2], 2'b00};
      idx = word_addr >> 2;
      if (idx < REG_WORDS) begin
        if (acc.kind == ACC_WRITE) begin
          reg_file[idx] = acc.write_data;
          if (word_addr == OFFSET_ADDR)
            frame_off = (acc.write_data >= FB_BASE) ? acc.write_data - FB_BASE : '0;
          else if (word_addr == PITCH_ADDR)
            line_pitch = acc.write_data;
        end else if (word_addr == ID_ADDR) begin
          rd = ID_VALUE;
        end else if (word_addr == STATUS_ADDR) begin
          rd = STATUS_VALUE;
        end else begin
          rd = reg_file[idx];
        end
      end
    end
    res.read_data   = (acc.kind == ACC_WRITE) ? '0 : rd;
    res.scan_start  = scan_origin();
    res.scan_pitch  = line_pitch;
    res.scan_active = (line_pitch != 0);
    return res;
  endfunction

  // Random transaction, weighted towards sequences that move the scan-out
  // start about: offset, pitch and control writes, plus a small working set
  // of registers so that reads hit stored words.
  function automatic req_t random_access();
    req_t        r;
    int unsigned pick;
    r.kind        = $urandom_range(0, 1);
    r.space       = SPACE_REG;
    r.address     = $urandom_range(0, 8191);
    r.access_size = $urandom_range(0, 7);
    r.write_data  = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      r.space = SPACE_CFG;
      if ($urandom_range(0, 9) != 0) begin
        r.access_size = $urandom_range(1, 4);
        r.address     = $urandom_range(0, CFG_SPACE_BYTES + 3);
      end
    end else if (pick < 40) begin
      r.kind    = ACC_WRITE;
      r.address = OFFSET_ADDR;
      r.address[1:0] = $urandom_range(0, 3);
      if ($urandom_range(0, 7) != 0) r.write_data = FB_BASE + $urandom_range(0, VRAM_BYTES);
    end else if (pick < 50) begin
      r.kind    = ACC_WRITE;
      r.address = PITCH_ADDR;
      r.address[1:0] = $urandom_range(0, 3);
      case ($urandom_range(0, 19))
        0:       r.write_data = '0;
        1, 2:    r.write_data = $urandom();
        default: r.write_data = $urandom_range(1, 4400);
      endcase
    end else if (pick < 58) begin
      r.kind    = ($urandom_range(0, 4) != 0) ? ACC_WRITE : ACC_READ;
      r.address = CTRL_ADDR;
      r.address[1:0] = $urandom_range(0, 3);
    end else if (pick < 66) begin
      r.kind = ACC_READ;
      case ($urandom_range(0, 4))
        0:       r.address = ID_ADDR;
        1:       r.address = STATUS_ADDR;
        2:       r.address = CTRL_ADDR;
        3:       r.address = OFFSET_ADDR;
        default: r.address = PITCH_ADDR;
      endcase
      r.address[1:0] = $urandom_range(0, 3);
    end else if (pick < 88) begin
      r.address = 13'h0400 + $urandom_range(0, 63);
    end
    return r;
  endfunction

  function automatic void add_row(bit kind, bit space, logic [ADDR_W-1:0] addr,
                                  logic [SIZE_W-1:0] size, logic [DATA_W-1:0] data,
                                  bit typed, logic [DATA_W-1:0] rd,
                                  logic [START_W-1:0] start, logic [DATA_W-1:0] pitch,
                                  bit active);
    access_row_t row;
    row.acc.kind             = kind;
    row.acc.space            = space;
    row.acc.address          = addr;
    row.acc.access_size      = size;
    row.acc.write_data       = data;
    row.typed                = typed;
    row.want.read_data       = rd;
    row.want.scan_start      = start;
    row.want.scan_pitch      = pitch;
    row.want.scan_active     = active;
    directed_rows.push_back(row);
  endfunction

  task automatic note_fault(input string what, input rsp_t want, input rsp_t got);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("%t %s: want rd=%h start=%h pitch=%h act=%b, got rd=%h start=%h pitch=%h act=%b",
               $realtime, what, want.read_data, want.scan_start, want.scan_pitch,
               want.scan_active, got.read_data, got.scan_start, got.scan_pitch,
               got.scan_active);
  endtask

  // Offer one transaction after a random gap and hold it until accepted
  task automatic send_access(input req_t acc, input bit typed, input rsp_t want);
    int unsigned gap;
    gap = gap_len();
    repeat (gap) begin
      @(negedge clk_i);
      req_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_bus.valid   <= 1'b1;
    req_bus.payload <= acc;
    row_typed       <= typed;
    row_want        <= want;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
  endtask

  // Result side: stall at random, with the same gap profile as the sender
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        rsp_bus.ready <= 1'b0;
        hold--;
      end else begin
        rsp_bus.ready <= 1'b1;
        hold = gap_len();
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation, then
  // predict for a transaction accepted at this edge. A result cannot belong
  // to the transaction accepted at the same edge, so the order is safe.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        note_fault("result with nothing pending", '0, rsp_bus.payload);
      end else begin
        want = pending_results.pop_front();
        if (rsp_bus.payload !== want) note_fault("result mismatch", want, rsp_bus.payload);
      end
    end
    if (rst_ni === 1'b1 && req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
      want = apply_access(req_bus.payload);
      if (row_typed) want = row_want;
      pending_results.push_back(want);
    end
  end

  initial begin : stimulus
    // Shadow state at reset
    foreach (reg_file[i]) reg_file[i] = '0;
    foreach (cfg_space[i]) cfg_space[i] = '0;
    frame_off   = '0;
    line_pitch  = PITCH_RESET;
    fault_count = 0;
    no_idle     = 1'b0;
    row_typed   = 1'b0;
    row_want    = '0;

    rst_ni          = 1'b0;
    req_bus.valid   = 1'b0;
    req_bus.payload = '0;

    // Directed table. Typed rows carry their expected result; the rest are
    // left to the predictor.
    //      kind       space      addr         sz    data                  typed rd            start   pitch          act
    add_row(ACC_READ,  SPACE_REG, ID_ADDR,     3'd0, 32'h0,                1, ID_VALUE,     21'd0,  32'd1280,       1);
    add_row(ACC_READ,  SPACE_REG, STATUS_ADDR, 3'd7, 32'h0,                1, STATUS_VALUE, 21'd0,  32'd1280,       1);
    // Last word, never written: still zero from reset
    add_row(ACC_READ,  SPACE_REG, 13'h1ffc,    3'd1, 32'h0,                1, 32'h0,        21'd0,  32'd1280,       1);
    add_row(ACC_WRITE, SPACE_REG, 13'h1ffc,    3'd4, 32'hffff_ffff,        1, 32'h0,        21'd0,  32'd1280,       1);
    // Unaligned: low address bits ignored
    add_row(ACC_READ,  SPACE_REG, 13'h1fff,    3'd2, 32'h0,                1, 32'hffff_ffff, 21'd0, 32'd1280,       1);
    add_row(ACC_WRITE, SPACE_CFG, 13'h0000,    3'd4, 32'h0403_0201,        1, 32'h0,        21'd0,  32'd1280,       1);
    // Size above four behaves as four
    add_row(ACC_READ,  SPACE_CFG, 13'h0000,    3'd7, 32'h0,                1, 32'h0403_0201, 21'd0, 32'd1280,       1);
    // Write across the end of the space: upper bytes dropped
    add_row(ACC_WRITE, SPACE_CFG, 13'h000e,    3'd4, 32'haabb_ccdd,        1, 32'h0,        21'd0,  32'd1280,       1);
    add_row(ACC_READ,  SPACE_CFG, 13'h000d,    3'd4, 32'h0,                1, 32'h00cc_dd00, 21'd0, 32'd1280,       1);
    // Zero size moves nothing
    add_row(ACC_READ,  SPACE_CFG, 13'h0000,    3'd0, 32'h0,                1, 32'h0,        21'd0,  32'd1280,       1);
    add_row(ACC_WRITE, SPACE_CFG, 13'h1fff,    3'd4, 32'h5a5a_a5a5,        1, 32'h0,        21'd0,  32'd1280,       1);
    add_row(ACC_READ,  SPACE_CFG, 13'h1fff,    3'd1, 32'h0,                1, 32'h0,        21'd0,  32'd1280,       1);
    // Offset below the frame-buffer base clamps to zero
    add_row(ACC_WRITE, SPACE_REG, OFFSET_ADDR, 3'd4, FB_BASE - 1,          1, 32'h0,        21'd0,  32'd1280,       1);
    add_row(ACC_WRITE, SPACE_REG, OFFSET_ADDR, 3'd4, FB_BASE + 32'h1000,   1, 32'h0,        21'd4096, 32'd1280,     1);
    add_row(ACC_READ,  SPACE_REG, OFFSET_ADDR, 3'd4, 32'h0,                1, FB_BASE + 32'h1000, 21'd4096, 32'd1280, 1);
    // Portrait: rotation base exceeds the offset, start clamps to zero
    add_row(ACC_WRITE, SPACE_REG, CTRL_ADDR,   3'd4, 32'h0000_0008,        1, 32'h0,        21'd0,  32'd1280,       1);
    add_row(ACC_WRITE, SPACE_REG, OFFSET_ADDR, 3'd4, FB_BASE + 32'h10_0000, 0, '0,          '0,     '0,             0);
    add_row(ACC_WRITE, SPACE_REG, CTRL_ADDR,   3'd4, 32'h0000_0010,        0, '0,           '0,     '0,             0);
    // Widest pitch that fits a frame: offset now pushes it past the end
    add_row(ACC_WRITE, SPACE_REG, PITCH_ADDR,  3'd4, 32'd4369,             1, 32'h0,        21'd0,  32'd4369,       1);
    add_row(ACC_WRITE, SPACE_REG, OFFSET_ADDR, 3'd4, FB_BASE + 32'd32,     0, '0,           '0,     '0,             0);
    add_row(ACC_WRITE, SPACE_REG, PITCH_ADDR,  3'd4, 32'h0,                0, '0,           '0,     '0,             0);
    // Zero pitch with the start right at the end of VRAM: masks to zero
    add_row(ACC_WRITE, SPACE_REG, OFFSET_ADDR, 3'd4, FB_BASE + VRAM_BYTES, 1, 32'h0,        21'd0,  32'h0,          0);
    add_row(ACC_WRITE, SPACE_REG, PITCH_ADDR,  3'd4, 32'hffff_ffff,        1, 32'h0,        21'd0,  32'hffff_ffff,  1);
    add_row(ACC_WRITE, SPACE_REG, CTRL_ADDR,   3'd4, 32'h0000_0018,        1, 32'h0,        21'd0,  32'hffff_ffff,  1);
    add_row(ACC_WRITE, SPACE_REG, PITCH_ADDR,  3'd4, 32'd1280,             0, '0,           '0,     '0,             0);

    // Hold reset, then release it on a falling edge
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Ready stays low through the register sweep; the first send just waits
    foreach (directed_rows[i])
      send_access(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].want);

    // Random part, in segments; every third segment runs with no idling
    for (int unsigned k = 0; k < RANDOM_ACCESSES; k++) begin
      no_idle = ((k / SEGMENT_LEN) % 3 == 2);
      send_access(random_access(), 1'b0, '0);
    end
    no_idle = 1'b0;

    @(negedge clk_i);
    req_bus.valid <= 1'b0;

    // Drain: wait for every owed result, then a few spare cycles
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_results.size() != 0) note_fault("results never arrived", '0, '0);

    if (fault_count == 0) begin
      $display("display_controller_register_block_top_test: done, clean");
    end else begin
      $display("display_controller_register_block_top_test: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
design/dcrb_pkg.sv
design/dcrb_if.sv
design/display_controller_register_block_top.sv
tb/display_controller_register_block_top_test.sv
